>>> hdl/gcov_pkg.sv
// gcov_pkg: shared types and constants for the grid coverage block
// no dependencies; imported by gcov_sq, gcov_div and the top module
package gcov_pkg;

  localparam int MAX_CIRCLES = 1024;
  localparam int MAX_SIDE    = 1024;

  localparam int ADDR_W   = $clog2(MAX_CIRCLES);
  localparam int COUNT_W  = $clog2(MAX_CIRCLES + 1);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int COORD_W  = 16;
  localparam int CIRCLE_W = 3 * COORD_W;
  // doubled cell centre (2*i+1)*cell_size
  localparam int POS_W    = IDX_W + 1 + COORD_W + 1;
  localparam int SQ_W     = 2 * POS_W;
  localparam int ACC_W    = SQ_W + 1;
  localparam int CELLS_W  = 21;
  localparam int FRAC_W   = 17;
  localparam int FRAC_SH  = 16;
  localparam int DIV_STEPS = FRAC_SH + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int IN_DATA_W  = CIRCLE_W;
  localparam int OUT_DATA_W = 64;

  localparam logic [SIDE_W-1:0]  CPS_RESET  = SIDE_W'(200);
  localparam logic [COORD_W-1:0] CSIZE_RESET = COORD_W'(128);

  typedef enum logic {
    REG_CELLS_PER_SIDE = 1'b0,
    REG_CELL_SIZE      = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_TOTAL,
    S_RD,
    S_SQX,
    S_SQY,
    S_SQR,
    S_CMP,
    S_DIV,
    S_DIVW,
    S_OUT
  } state_t;

endpackage

>>> hdl/gcov_ram.sv
// gcov_ram: generic single write port, single read port ram with registered read
// no dependencies
module gcov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gcov_sq.sv
// gcov_sq: shared squaring unit with registered product
// depends on gcov_pkg
module gcov_sq (
  input  logic                      clk,
  input  logic [gcov_pkg::POS_W-1:0] op,
  output logic [gcov_pkg::SQ_W-1:0]  sq
);
  import gcov_pkg::*;

  always_ff @(posedge clk) begin
    sq <= op * op;
  end

endmodule

>>> hdl/gcov_div.sv
// gcov_div: restoring divider, one quotient bit per cycle, gives covered*2^16/total
// depends on gcov_pkg; expects covered <= total and total > 0
module gcov_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gcov_pkg::CELLS_W-1:0] covered,
  input  logic [gcov_pkg::CELLS_W-1:0] total,
  output logic                        done,
  output logic [gcov_pkg::FRAC_W-1:0]  quot
);
  import gcov_pkg::*;

  logic [CELLS_W:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic               ge;
  logic [CELLS_W:0]   rem_sub;

  assign ge      = rem >= {1'b0, total};
  assign rem_sub = ge ? rem - {1'b0, total} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, covered};
      quot <= '0;
    end else if (busy) begin
      // remainder stays below total, so the shift cannot lose a bit
      rem  <= {rem_sub[CELLS_W-1:0], 1'b0};
      quot <= {quot[FRAC_W-2:0], ge};
    end
  end

endmodule

>>> hdl/grid_coverage_of_circles_top.sv
// grid coverage of circles: a circle word is stored when taken, one per cycle while idle.
// a compute word starts a walk that tests each cell against the stored circles in turn
// (a cell stops at its first hit, an empty store skips the walk), then a division and
// an output load; one squaring unit is shared; no word is taken meanwhile, longer on stall.
// reset (synchronous) empties the store, clears the overflow flag and output valid,
// and sets cells_per_side 200 and cell edge 128; store contents stay undefined.
module grid_coverage_of_circles_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gcov_pkg::IN_DATA_W-1:0]   s_tdata,   // centre_x, centre_y, radius
  input  logic [0:0]                       s_tuser,   // command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gcov_pkg::OUT_DATA_W-1:0]  m_tdata,   // covered_cells, cell total,
                                                      // cover_fraction, overflowed, zero fill
  input  logic                             cfg_wen,
  input  logic [0:0]                       cfg_index,
  input  logic [gcov_pkg::COORD_W-1:0]     cfg_data
);
  import gcov_pkg::*;

  state_t state, state_next;

  logic [SIDE_W-1:0]  cells_per_side;
  logic [COORD_W-1:0] cell_edge;
  logic [COUNT_W-1:0] count;
  logic               overflow;

  logic [SIDE_W-1:0]  side;
  logic [IDX_W-1:0]   xi, yi;
  logic [POS_W-1:0]   px, py;
  logic [ADDR_W-1:0]  k;
  logic [ACC_W-1:0]   acc;
  logic [CELLS_W-1:0] covered, total;

  logic [CIRCLE_W-1:0] rdata;
  logic [POS_W-1:0]    sq_op;
  logic [SQ_W-1:0]     sq;
  logic                div_start, div_done;
  logic [FRAC_W-1:0]   quot;

  logic               s_acc;
  logic               out_free;
  logic [POS_W-1:0]   cx2, cy2, dx, dy, r2, step2;
  logic               hit, last_circle, last_x, last_y;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign cx2   = POS_W'({rdata[COORD_W-1:0], 1'b0});
  assign cy2   = POS_W'({rdata[2*COORD_W-1:COORD_W], 1'b0});
  assign r2    = POS_W'({rdata[3*COORD_W-1:2*COORD_W], 1'b0});
  assign dx    = (px >= cx2) ? px - cx2 : cx2 - px;
  assign dy    = (py >= cy2) ? py - cy2 : cy2 - py;
  assign step2 = POS_W'({cell_edge, 1'b0});

  assign hit         = acc <= ACC_W'(sq);
  assign last_circle = {1'b0, k} == count - 1'b1;
  assign last_x      = {1'b0, xi} == side - 1'b1;
  assign last_y      = {1'b0, yi} == side - 1'b1;

  gcov_ram #(
    .WIDTH(CIRCLE_W),
    .DEPTH(MAX_CIRCLES)
  ) u_store (
    .clk  (clk),
    .we   (s_acc && s_tuser[0] == CMD_ADD && count < COUNT_W'(MAX_CIRCLES)),
    .waddr(count[ADDR_W-1:0]),
    .wdata(s_tdata),
    .raddr(k),
    .rdata(rdata)
  );

  gcov_sq u_sq (
    .clk(clk),
    .op (sq_op),
    .sq (sq)
  );

  gcov_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .covered(covered),
    .total  (total),
    .done   (div_done),
    .quot   (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_op      = POS_W'(side);
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_acc && s_tuser[0] == CMD_COMPUTE) begin
          state_next = S_START;
        end
      end
      S_START: state_next = S_TOTAL;
      S_TOTAL: state_next = (count == '0) ? S_DIV : S_RD;
      S_RD:    state_next = S_SQX;
      S_SQX: begin
        sq_op      = dx;
        state_next = S_SQY;
      end
      S_SQY: begin
        sq_op      = dy;
        state_next = S_SQR;
      end
      S_SQR: begin
        sq_op      = r2;
        state_next = S_CMP;
      end
      S_CMP: begin
        if ((hit || last_circle) && last_x && last_y) begin
          state_next = S_DIV;
        end else begin
          state_next = S_RD;
        end
      end
      S_DIV: begin
        div_start  = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // config registers and store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_side <= CPS_RESET;
      cell_edge      <= CSIZE_RESET;
      count          <= '0;
      overflow       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CELLS_PER_SIDE: cells_per_side <= cfg_data[SIDE_W-1:0];
          REG_CELL_SIZE:      cell_edge      <= cfg_data;
        endcase
      end
      if (s_acc && s_tuser[0] == CMD_ADD) begin
        if (count < COUNT_W'(MAX_CIRCLES)) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (state == S_OUT && out_free) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  // grid walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        // limit the side count to 1..MAX_SIDE
        if (cells_per_side == '0) begin
          side <= SIDE_W'(1);
        end else if (cells_per_side > SIDE_W'(MAX_SIDE)) begin
          side <= SIDE_W'(MAX_SIDE);
        end else begin
          side <= cells_per_side;
        end
      end
      S_TOTAL: begin
        total   <= sq[CELLS_W-1:0];
        covered <= '0;
        xi      <= '0;
        yi      <= '0;
        k       <= '0;
        px      <= POS_W'(cell_edge);
        py      <= POS_W'(cell_edge);
      end
      S_SQY: acc <= ACC_W'(sq);
      S_SQR: acc <= acc + ACC_W'(sq);
      S_CMP: begin
        if (hit || last_circle) begin
          if (hit) begin
            covered <= covered + 1'b1;
          end
          k <= '0;
          if (last_x) begin
            xi <= '0;
            px <= POS_W'(cell_edge);
            yi <= yi + 1'b1;
            py <= py + step2;
          end else begin
            xi <= xi + 1'b1;
            px <= px + step2;
          end
        end else begin
          k <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= OUT_DATA_W'({overflow, quot, total, covered});
    end
  end

endmodule
